/* rtl/core/prufd_pkg.sv */
package prufd_pkg;

  // Sizes of the node store and the fields.
  localparam int NODES  = 4096;
  localparam int IDX_W  = 12;
  localparam int SIZE_W = 13;
  localparam int PROD_W = 24;
  localparam int POS_W  = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX  = 13'h1FFF;
  localparam logic [PROD_W-1:0] PROD_MAX  = 24'hFFFFFF;
  localparam logic [POS_W-1:0]  POS_LIMIT = 4'd15;
  localparam logic [SIZE_W-1:0] NODES_SZ  = 13'd4096;

  // Command codes of an input item.
  localparam logic CMD_BOND  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // One node entry: a root holds its cluster size, other nodes a parent index.
  typedef struct packed {
    logic              root;
    logic [SIZE_W-1:0] link;
  } entry_t;

  // Access request to the node store.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] node_a;
    logic [IDX_W-1:0] node_b;
    logic             last_candidate;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  selected_index;
    logic [SIZE_W-1:0] largest_size;
    logic              merged;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_W1, S_W2, S_FB, S_PROD, S_BEST, S_MA, S_MB, S_MW, S_LF
  } state_t;

  typedef enum logic [1:0] {
    PH_A, PH_B, PH_L
  } phase_t;

endpackage

/* rtl/core/product_rule_union_find.sv */
// Product-rule union-find engine for explosive percolation.
// Command channel: an item (item) is taken on a clock edge where start is high
// and busy is low. A candidate bond item finds both roots with path
// compression and keeps the first candidate with the smallest size product.
// An item with last_candidate set also merges the kept bond by union by size
// and then produces one result: done is high for exactly one cycle with
// selected_index, largest_size and merged on result. The receiver cannot
// stall, so the result is lost if not taken in that cycle.
// A clear item resets the nodes in use to singletons, one entry per cycle,
// and produces no result.
// A root search reads each node on the path up to the root, then a compressing
// pass rewrites the nodes of that path to point at the root. A candidate holds
// busy through the root searches of both its ends and the product step. The
// last candidate of a step adds the merge steps and a root search from the kept
// first root; done rises in the same cycle that busy falls. A clear holds busy
// while it sweeps the effective node count (node_count clamped to 1..4096) of
// entries. After reset the block is busy while the whole store is swept to
// singletons.
// node_count is written through the APB port at byte address 0.
module product_rule_union_find (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  prufd_pkg::in_item_t   item,
  output logic                  done,
  output prufd_pkg::out_item_t  result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [prufd_pkg::SIZE_W-1:0] node_count;
  prufd_pkg::ram_req_t          req;
  prufd_pkg::entry_t            rdata;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= prufd_pkg::NODES_SZ;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      node_count <= pwdata[prufd_pkg::SIZE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - prufd_pkg::SIZE_W){1'b0}}, node_count};

  prufd_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  prufd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .node_count (node_count),
    .rdata      (rdata),
    .req        (req),
    .busy       (busy),
    .done       (done),
    .result     (result)
  );

endmodule

/* rtl/core/prufd_ram.sv */
module prufd_ram (
  input  logic               clk,
  input  prufd_pkg::ram_req_t req,
  output prufd_pkg::entry_t   rdata
);

  prufd_pkg::entry_t mem [prufd_pkg::NODES];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* rtl/core/prufd_ctrl.sv */
module prufd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  prufd_pkg::in_item_t           item,
  input  logic [prufd_pkg::SIZE_W-1:0]  node_count,
  input  prufd_pkg::entry_t             rdata,
  output prufd_pkg::ram_req_t           req,
  output logic                          busy,
  output logic                          done,
  output prufd_pkg::out_item_t          result
);

  localparam int IW = prufd_pkg::IDX_W;
  localparam int SW = prufd_pkg::SIZE_W;

  prufd_pkg::state_t state, state_next;
  prufd_pkg::phase_t phase, phase_next;

  logic [IW-1:0] cur, cur_next, start_node, start_node_next;
  logic [IW-1:0] root_r, root_r_next;
  logic [SW-1:0] root_size, root_size_next;
  logic [IW-1:0] node_b_r, node_b_r_next;
  logic          last_r, last_r_next;
  logic [IW-1:0] ra, ra_next, rb, rb_next;
  logic [SW-1:0] sa, sa_next, sb, sb_next;
  logic [2*SW-1:0] prod, prod_next;
  logic [prufd_pkg::PROD_W-1:0] best_product, best_product_next;
  logic [IW-1:0] best_root_a, best_root_a_next, best_root_b, best_root_b_next;
  logic [prufd_pkg::POS_W-1:0] best_position, best_position_next;
  logic [prufd_pkg::POS_W-1:0] counter, counter_next;
  logic [SW-1:0] largest, largest_next;
  prufd_pkg::entry_t ea, ea_next;
  logic [IW-1:0] keep, keep_next, drop, drop_next;
  logic          merged, merged_next;
  logic [IW-1:0] clr_idx, clr_idx_next, clr_last, clr_last_next;
  logic          done_next;
  prufd_pkg::out_item_t result_next;

  logic [SW-1:0] eff;
  logic [IW-1:0] a_sat, b_sat, nxt;
  logic          find_done;
  logic [IW-1:0] fr;
  logic [SW-1:0] fs;
  logic [prufd_pkg::PROD_W-1:0] prod_sat;
  logic [SW:0]   sum;

  // Effective node count and saturated endpoints.
  always_comb begin
    if (node_count == '0) begin
      eff = SW'(1);
    end else if (node_count > prufd_pkg::NODES_SZ) begin
      eff = prufd_pkg::NODES_SZ;
    end else begin
      eff = node_count;
    end
    a_sat = ({1'b0, item.node_a} >= eff) ? IW'(eff - SW'(1)) : item.node_a;
    b_sat = ({1'b0, item.node_b} >= eff) ? IW'(eff - SW'(1)) : item.node_b;
  end

  // End of a root search and the root it found.
  always_comb begin
    nxt       = rdata.link[IW-1:0];
    find_done = 1'b0;
    fr        = root_r;
    fs        = root_size;
    case (state)
      prufd_pkg::S_W1: begin
        if (rdata.root && cur == start_node) begin
          find_done = 1'b1;
          fr        = cur;
          fs        = rdata.link;
        end
      end
      prufd_pkg::S_W2: begin
        find_done = rdata.root || cur == root_r || nxt == root_r;
      end
      default: begin
        find_done = 1'b0;
      end
    endcase
    prod_sat = (prod > (2*SW)'(prufd_pkg::PROD_MAX)) ? prufd_pkg::PROD_MAX
                                                      : prod[prufd_pkg::PROD_W-1:0];
    sum = {1'b0, ea.link} + {1'b0, rdata.link};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      prufd_pkg::S_CLR: begin
        if (clr_idx == clr_last) state_next = prufd_pkg::S_IDLE;
      end
      prufd_pkg::S_IDLE: begin
        if (start) begin
          state_next = (item.cmd == prufd_pkg::CMD_CLEAR) ? prufd_pkg::S_CLR
                                                          : prufd_pkg::S_W1;
        end
      end
      prufd_pkg::S_W1, prufd_pkg::S_W2: begin
        if (find_done) begin
          case (phase)
            prufd_pkg::PH_A: state_next = prufd_pkg::S_FB;
            prufd_pkg::PH_B: state_next = prufd_pkg::S_PROD;
            default:         state_next = prufd_pkg::S_IDLE;
          endcase
        end else if (state == prufd_pkg::S_W1 && rdata.root) begin
          state_next = prufd_pkg::S_W2;
        end
      end
      prufd_pkg::S_FB:   state_next = prufd_pkg::S_W1;
      prufd_pkg::S_PROD: state_next = prufd_pkg::S_BEST;
      prufd_pkg::S_BEST: state_next = last_r ? prufd_pkg::S_MA : prufd_pkg::S_IDLE;
      prufd_pkg::S_MA:   state_next = prufd_pkg::S_MB;
      prufd_pkg::S_MB: begin
        if (best_root_a != best_root_b && ea.root && rdata.root) begin
          state_next = prufd_pkg::S_MW;
        end else begin
          state_next = prufd_pkg::S_LF;
        end
      end
      prufd_pkg::S_MW:   state_next = prufd_pkg::S_LF;
      prufd_pkg::S_LF:   state_next = prufd_pkg::S_W1;
      default:           state_next = prufd_pkg::S_IDLE;
    endcase
  end

  // Datapath updates and memory requests.
  always_comb begin
    req                = '0;
    phase_next         = phase;
    cur_next           = cur;
    start_node_next    = start_node;
    root_r_next        = root_r;
    root_size_next     = root_size;
    node_b_r_next      = node_b_r;
    last_r_next        = last_r;
    ra_next            = ra;
    rb_next            = rb;
    sa_next            = sa;
    sb_next            = sb;
    prod_next          = prod;
    best_product_next  = best_product;
    best_root_a_next   = best_root_a;
    best_root_b_next   = best_root_b;
    best_position_next = best_position;
    counter_next       = counter;
    largest_next       = largest;
    ea_next            = ea;
    keep_next          = keep;
    drop_next          = drop;
    merged_next        = merged;
    clr_idx_next       = clr_idx;
    clr_last_next      = clr_last;
    done_next          = 1'b0;
    result_next        = result;
    case (state)
      prufd_pkg::S_CLR: begin
        req.we       = 1'b1;
        req.waddr    = clr_idx;
        req.wdata    = '{root: 1'b1, link: SW'(1)};
        clr_idx_next = clr_idx + IW'(1);
      end
      prufd_pkg::S_IDLE: begin
        if (start) begin
          if (item.cmd == prufd_pkg::CMD_CLEAR) begin
            clr_idx_next  = '0;
            clr_last_next = IW'(eff - SW'(1));
            counter_next  = '0;
            largest_next  = '0;
          end else begin
            node_b_r_next   = b_sat;
            last_r_next     = item.last_candidate;
            cur_next        = a_sat;
            start_node_next = a_sat;
            phase_next      = prufd_pkg::PH_A;
            req.re          = 1'b1;
            req.raddr       = a_sat;
          end
        end
      end
      prufd_pkg::S_W1: begin
        // Walk up to the root.
        if (rdata.root) begin
          root_r_next    = cur;
          root_size_next = rdata.link;
          if (cur != start_node) begin
            cur_next  = start_node;
            req.re    = 1'b1;
            req.raddr = start_node;
          end
        end else begin
          cur_next  = nxt;
          req.re    = 1'b1;
          req.raddr = nxt;
        end
      end
      prufd_pkg::S_W2: begin
        // Second walk points every visited node at the root.
        if (!(rdata.root || cur == root_r)) begin
          req.we    = 1'b1;
          req.waddr = cur;
          req.wdata = '{root: 1'b0, link: {1'b0, root_r}};
          if (nxt != root_r) begin
            cur_next  = nxt;
            req.re    = 1'b1;
            req.raddr = nxt;
          end
        end
      end
      prufd_pkg::S_FB: begin
        cur_next        = node_b_r;
        start_node_next = node_b_r;
        phase_next      = prufd_pkg::PH_B;
        req.re          = 1'b1;
        req.raddr       = node_b_r;
      end
      prufd_pkg::S_PROD: begin
        prod_next = sa * sb;
      end
      prufd_pkg::S_BEST: begin
        if (counter == '0 || prod_sat < best_product) begin
          best_product_next  = prod_sat;
          best_root_a_next   = ra;
          best_root_b_next   = rb;
          best_position_next = counter;
        end
        if (counter < prufd_pkg::POS_LIMIT) counter_next = counter + 1'b1;
        if (last_r) begin
          req.re    = 1'b1;
          req.raddr = (counter == '0 || prod_sat < best_product) ? ra : best_root_a;
        end
      end
      prufd_pkg::S_MA: begin
        ea_next   = rdata;
        req.re    = 1'b1;
        req.raddr = best_root_b;
      end
      prufd_pkg::S_MB: begin
        // Union by size; on a tie the first root stays root.
        if (best_root_a != best_root_b && ea.root && rdata.root) begin
          merged_next = 1'b1;
          if (rdata.link > ea.link) begin
            keep_next = best_root_b;
            drop_next = best_root_a;
          end else begin
            keep_next = best_root_a;
            drop_next = best_root_b;
          end
          req.we    = 1'b1;
          req.waddr = (rdata.link > ea.link) ? best_root_b : best_root_a;
          req.wdata = '{root: 1'b1,
                        link: (sum > {1'b0, prufd_pkg::SIZE_MAX}) ? prufd_pkg::SIZE_MAX
                                                                 : sum[SW-1:0]};
        end else begin
          merged_next = 1'b0;
        end
      end
      prufd_pkg::S_MW: begin
        req.we    = 1'b1;
        req.waddr = drop;
        req.wdata = '{root: 1'b0, link: {1'b0, keep}};
      end
      prufd_pkg::S_LF: begin
        cur_next        = best_root_a;
        start_node_next = best_root_a;
        phase_next      = prufd_pkg::PH_L;
        req.re          = 1'b1;
        req.raddr       = best_root_a;
      end
      default: begin
        req = '0;
      end
    endcase

    // Hand the found root to whoever asked for it.
    if (find_done) begin
      case (phase)
        prufd_pkg::PH_A: begin
          ra_next = fr;
          sa_next = fs;
        end
        prufd_pkg::PH_B: begin
          rb_next = fr;
          sb_next = fs;
        end
        default: begin
          largest_next               = (fs > largest) ? fs : largest;
          result_next.selected_index = best_position;
          result_next.largest_size   = (fs > largest) ? fs : largest;
          result_next.merged         = merged;
          done_next                  = 1'b1;
          counter_next               = '0;
        end
      endcase
    end
  end

  // Registers; after reset the store is swept to singletons.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= prufd_pkg::S_CLR;
      phase         <= prufd_pkg::PH_A;
      clr_idx       <= '0;
      clr_last      <= IW'(prufd_pkg::NODES - 1);
      counter       <= '0;
      largest       <= '0;
      best_product  <= '0;
      best_root_a   <= '0;
      best_root_b   <= '0;
      best_position <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      clr_idx       <= clr_idx_next;
      clr_last      <= clr_last_next;
      counter       <= counter_next;
      largest       <= largest_next;
      best_product  <= best_product_next;
      best_root_a   <= best_root_a_next;
      best_root_b   <= best_root_b_next;
      best_position <= best_position_next;
      done          <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    start_node <= start_node_next;
    root_r     <= root_r_next;
    root_size  <= root_size_next;
    node_b_r   <= node_b_r_next;
    last_r     <= last_r_next;
    ra         <= ra_next;
    rb         <= rb_next;
    sa         <= sa_next;
    sb         <= sb_next;
    prod       <= prod_next;
    ea         <= ea_next;
    keep       <= keep_next;
    drop       <= drop_next;
    merged     <= merged_next;
    result     <= result_next;
  end

  assign busy = (state != prufd_pkg::S_IDLE);

  // A write and a read in the same cycle never target the same entry.
  assert property (@(posedge clk) disable iff (rst)
    (req.we && req.re) |-> (req.waddr != req.raddr))
    else $error("store write and read collide");

  // A result only follows the end of a root search.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == prufd_pkg::S_W1 || $past(state) == prufd_pkg::S_W2))
    else $error("result without a finished search");

  // A clearing sweep runs to its last entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == prufd_pkg::S_CLR && clr_idx != clr_last) |=> state == prufd_pkg::S_CLR)
    else $error("clearing sweep cut short");

endmodule

/* tb/sv/tb_product_rule_union_find.sv */
module tb_product_rule_union_find;

  localparam int WDOG_LIMIT = 40000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  prufd_pkg::in_item_t  item;
  logic                 done;
  prufd_pkg::out_item_t result;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  product_rule_union_find DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Predictor state: a shadow of the node store and the step registers.
  logic                         pr_is_root [prufd_pkg::NODES];
  logic [prufd_pkg::SIZE_W-1:0] pr_link [prufd_pkg::NODES];
  int unsigned                  pr_nodes;
  logic [prufd_pkg::SIZE_W-1:0] pr_largest;
  logic [prufd_pkg::PROD_W-1:0] pr_best_prod;
  logic [prufd_pkg::IDX_W-1:0]  pr_best_ra;
  logic [prufd_pkg::IDX_W-1:0]  pr_best_rb;
  logic [prufd_pkg::POS_W-1:0]  pr_best_pos;
  logic [prufd_pkg::POS_W-1:0]  pr_cand_cnt;

  prufd_pkg::in_item_t  pending_items[$];
  prufd_pkg::out_item_t expected_results[$];
  int          errors;
  int          idle_cycles;
  bit          allow_gaps;
  int          gap_left;
  bit          hold_sender;

  always #5 clk = ~clk;

  // Walk to the root of a node and compress the walked path onto it.
  function automatic int unsigned find_root(int unsigned x);
    int unsigned r;
    int unsigned cur;
    int unsigned nxt;
    int unsigned steps;
    r = x % prufd_pkg::NODES;
    steps = 0;
    while (!pr_is_root[r] && steps < prufd_pkg::NODES) begin
      r = pr_link[r] % prufd_pkg::NODES;
      steps++;
    end
    cur = x % prufd_pkg::NODES;
    steps = 0;
    while (cur != r && !pr_is_root[cur] && steps < prufd_pkg::NODES) begin
      nxt = pr_link[cur] % prufd_pkg::NODES;
      pr_link[cur] = r[prufd_pkg::SIZE_W-1:0];
      cur = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic void make_singletons(int unsigned cnt);
    for (int unsigned i = 0; i < cnt && i < prufd_pkg::NODES; i++) begin
      pr_is_root[i] = 1'b1;
      pr_link[i] = prufd_pkg::SIZE_W'(1);
    end
  endfunction

  // Add an expected result at the tail of its queue.
  function automatic void expect_result(prufd_pkg::out_item_t res);
    expected_results = {expected_results, res};
  endfunction

  // Add an input item at the tail of the pending queue.
  function automatic void enqueue_item(prufd_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  // Apply one accepted transaction to the predictor, queueing any result.
  function automatic void predict_percolation(prufd_pkg::in_item_t it);
    int unsigned eff;
    int unsigned a;
    int unsigned b;
    int unsigned ra;
    int unsigned rb;
    int unsigned sa;
    int unsigned sb;
    int unsigned keep;
    int unsigned drop;
    int unsigned sum;
    int unsigned after;
    longint unsigned prod;
    bit merged;
    prufd_pkg::out_item_t res;
    eff = pr_nodes < 1 ? 1 : (pr_nodes > prufd_pkg::NODES ? prufd_pkg::NODES : pr_nodes);
    if (it.cmd == prufd_pkg::CMD_CLEAR) begin
      make_singletons(eff);
      pr_largest = '0;
      pr_cand_cnt = '0;
      return;
    end
    a = it.node_a;
    b = it.node_b;
    if (a >= eff) a = eff - 1;
    if (b >= eff) b = eff - 1;
    ra = find_root(a);
    rb = find_root(b);
    sa = pr_is_root[ra] ? pr_link[ra] : 0;
    sb = pr_is_root[rb] ? pr_link[rb] : 0;
    prod = longint'(sa) * sb;
    if (prod > prufd_pkg::PROD_MAX) prod = prufd_pkg::PROD_MAX;
    if (pr_cand_cnt == 0 || prod < pr_best_prod) begin
      pr_best_prod = prod[prufd_pkg::PROD_W-1:0];
      pr_best_ra = ra[prufd_pkg::IDX_W-1:0];
      pr_best_rb = rb[prufd_pkg::IDX_W-1:0];
      pr_best_pos = pr_cand_cnt;
    end
    if (pr_cand_cnt < prufd_pkg::POS_LIMIT) pr_cand_cnt++;
    if (!it.last_candidate) return;
    ra = pr_best_ra;
    rb = pr_best_rb;
    merged = 1'b0;
    if (ra != rb && pr_is_root[ra] && pr_is_root[rb]) begin
      keep = ra;
      drop = rb;
      if (pr_link[rb] > pr_link[ra]) begin
        keep = rb;
        drop = ra;
      end
      sum = pr_link[keep] + pr_link[drop];
      if (sum > prufd_pkg::SIZE_MAX) sum = prufd_pkg::SIZE_MAX;
      pr_link[keep] = sum[prufd_pkg::SIZE_W-1:0];
      pr_is_root[drop] = 1'b0;
      pr_link[drop] = keep[prufd_pkg::SIZE_W-1:0];
      merged = 1'b1;
    end
    ra = find_root(ra);
    after = pr_is_root[ra] ? pr_link[ra] : 0;
    if (after > pr_largest) pr_largest = after[prufd_pkg::SIZE_W-1:0];
    res.selected_index = pr_best_pos;
    res.largest_size = pr_largest;
    res.merged = merged;
    expect_result(res);
    pr_cand_cnt = '0;
  endfunction

  // Driver: present queued items, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) predict_percolation(item);
      if (start && busy) begin
        // Keep the current transaction on the port until it is accepted.
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (hold_sender || pending_items.size() == 0) begin
        start <= 1'b0;
      end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 7);
      end else begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: compare every result strobe with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        prufd_pkg::out_item_t exp_res;
        exp_res = expected_results.pop_front();
        if (result.selected_index !== exp_res.selected_index) begin
          $display("%0t: selected_index expected %0d actual %0d", $time,
                   exp_res.selected_index, result.selected_index);
          errors++;
        end
        if (result.largest_size !== exp_res.largest_size) begin
          $display("%0t: largest_size expected %0d actual %0d", $time,
                   exp_res.largest_size, result.largest_size);
          errors++;
        end
        if (result.merged !== exp_res.merged) begin
          $display("%0t: merged expected %0d actual %0d", $time,
                   exp_res.merged, result.merged);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Write node_count through the APB port and mirror it in the predictor.
  task automatic write_node_count(int unsigned val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pr_nodes = val & 32'h1FFF;
  endtask

  // Wait for all expectations plus any trailing busy work.
  task automatic drain_block();
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    while (busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic prufd_pkg::in_item_t bond(int unsigned a, int unsigned b, bit last);
    prufd_pkg::in_item_t it;
    it.cmd = prufd_pkg::CMD_BOND;
    it.node_a = prufd_pkg::IDX_W'(a);
    it.node_b = prufd_pkg::IDX_W'(b);
    it.last_candidate = last;
    return it;
  endfunction

  function automatic prufd_pkg::in_item_t clear_item();
    prufd_pkg::in_item_t it;
    it.cmd = prufd_pkg::CMD_CLEAR;
    it.node_a = prufd_pkg::IDX_W'($urandom);
    it.node_b = prufd_pkg::IDX_W'($urandom);
    it.last_candidate = 1'($urandom);
    return it;
  endfunction

  // Queue one step of random candidate bonds over nodes below span.
  task automatic queue_step(int unsigned span, int unsigned ncand);
    for (int unsigned k = 0; k < ncand; k++)
      enqueue_item(bond($urandom_range(0, span - 1),
                        $urandom_range(0, span - 1), k == ncand - 1));
  endtask

  initial begin
    int unsigned counts[5];
    int unsigned span;
    int unsigned half;
    clk = 1'b0;
    rst = 1'b1;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    allow_gaps = 1'b1;
    hold_sender = 1'b0;
    pr_nodes = 4096;
    pr_largest = '0;
    pr_best_prod = '0;
    pr_best_ra = '0;
    pr_best_rb = '0;
    pr_best_pos = '0;
    pr_cand_cnt = '0;
    make_singletons(prufd_pkg::NODES);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: extremes, self loop, tie, many candidates, clear.
    enqueue_item(bond(4095, 0, 1'b1));
    enqueue_item(bond(7, 7, 1'b1));
    enqueue_item(bond(1, 2, 1'b0));
    enqueue_item(bond(3, 4, 1'b1));
    enqueue_item(bond(1, 3, 1'b1));
    enqueue_item(bond(0, 4095, 1'b1));
    for (int i = 0; i < 18; i++)
      enqueue_item(bond(100 + i, 2000 + i, i == 17));
    enqueue_item(clear_item());
    drain_block();

    // A small node count exercises saturation of indices.
    write_node_count(8);
    enqueue_item(bond(4095, 12'hAAA, 1'b1));
    enqueue_item(bond(12'h555, 0, 1'b1));
    drain_block();

    // Random phases over several node counts, the extremes included.
    counts = '{1, 4096, 16, 8191, 64};
    foreach (counts[p]) begin
      write_node_count(counts[p]);
      enqueue_item(clear_item());
      span = counts[p] > 4096 ? 4096 : counts[p];
      for (int s = 0; s < 70; s++) begin
        if ($urandom_range(0, 30) == 0) enqueue_item(clear_item());
        if ($urandom_range(0, 9) == 0)
          queue_step(4096, $urandom_range(1, 20));
        else
          queue_step($urandom_range(0, 1) ? span : (span < 32 ? span : 32),
                     $urandom_range(1, 5));
      end
      if (p == 3) begin
        // Halfway through, pause the sender until everything in flight returns.
        half = pending_items.size() / 2;
        while (pending_items.size() > half) @(posedge clk);
        hold_sender = 1'b1;
        while (expected_results.size() != 0 || start || busy) @(posedge clk);
        hold_sender = 1'b0;
      end
      if (p == 4) allow_gaps = 1'b0;
      drain_block();
    end
    write_node_count(0);
    enqueue_item(clear_item());
    queue_step(4096, 3);
    drain_block();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/prufd_pkg.sv
rtl/core/prufd_ram.sv
rtl/core/prufd_ctrl.sv
rtl/core/product_rule_union_find.sv
tb/sv/tb_product_rule_union_find.sv
